// ===== rtl/core/i2c_adm_pkg.sv =====
// Shared types and constants for the I2C converter transaction master.
// Item structs, sequencer phase codes and sequencer state. No dependencies.
`timescale 1ns / 1ps

package i2c_adm_pkg;

  localparam logic [6:0] DevAddrReset = 7'd72;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_READ  = 2'd1,
    CMD_WRITE = 2'd2
  } cmd_e;

  typedef enum logic [4:0] {
    PH_IDLE     = 5'd0,
    PH_START2   = 5'd1,
    PH_ADDRW    = 5'd2,
    PH_ADDRW_A1 = 5'd3,
    PH_ADDRW_A2 = 5'd4,
    PH_CTRL     = 5'd5,
    PH_CTRL_A1  = 5'd6,
    PH_CTRL_A2  = 5'd7,
    PH_DATA     = 5'd8,
    PH_DATA_A1  = 5'd9,
    PH_DATA_A2  = 5'd10,
    PH_ADDRR    = 5'd11,
    PH_ADDRR_A1 = 5'd12,
    PH_ADDRR_A2 = 5'd13,
    PH_STOPM1   = 5'd14,
    PH_STOPM2   = 5'd15,
    PH_START1R  = 5'd16,
    PH_START2R  = 5'd17,
    PH_RECV     = 5'd18,
    PH_NACK1    = 5'd19,
    PH_NACK2    = 5'd20,
    PH_STOP1    = 5'd21,
    PH_STOP2    = 5'd22
  } phase_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] control_byte;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    phase_e     phase;
    logic [3:0] bit_count;
    logic [7:0] shift_byte;
    logic       is_read;
    logic [7:0] saved_control;
    logic [7:0] saved_data;
    logic [7:0] received_byte;
    logic       error_flag;
    logic       scl;
    logic       sda;
  } seq_state_t;

endpackage

// ===== rtl/core/i2c_adc_dac_transaction_master_unit.sv =====
// Top level of the I2C converter transaction master.
// Holds sequencer state, the address register and the result register;
// uses i2c_adm_pkg and i2c_adm_seq.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o / in_item_i): one item per bus
//   timing tick. command starts a converter read or write when the sequencer
//   is idle; sda_in is the sampled SDA level for that tick.
//   Output channel (out_valid_o / out_ready_i / out_item_o): exactly one
//   result item per input item, carrying the SCL/SDA drive levels, busy,
//   done, last read byte and ack error.
//   Config: cfg_we_i writes the 7-bit device address from cfg_data_i; write
//   it only while no transaction runs.
// Timing
//   An accepted item's result sits in the output register on the next cycle.
//   Throughput is one item per cycle while the output is not stalled, bounded
//   by the state update loop through i2c_adm_seq.
// Reset
//   Sequencer idle, both lines released high, read byte and error cleared,
//   device address 72, output register empty.
// Stall
//   While a result is held and out_ready_i is low, in_ready_o is low and the
//   sequencer state does not advance; no item is lost or repeated.

module i2c_adc_dac_transaction_master_unit (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  i2c_adm_pkg::in_item_t  in_item_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output i2c_adm_pkg::out_item_t out_item_o,
  input  logic                   cfg_we_i,
  input  logic [6:0]             cfg_data_i
);
  import i2c_adm_pkg::*;

  seq_state_t st_q, st_d;
  out_item_t  res_q, res_d;
  logic       out_valid_q;
  logic [6:0] dev_addr_q;
  logic       in_acc;

  // Result register frees up when empty or being drained this cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  i2c_adm_seq u_seq (
    .st_i       (st_q),
    .item_i     (in_item_i),
    .dev_addr_i (dev_addr_q),
    .st_o       (st_d),
    .res_o      (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DevAddrReset;
    end else if (cfg_we_i) begin
      dev_addr_q <= cfg_data_i;
    end
  end

  // Sequencer state: reset gives idle with lines released.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.phase         <= PH_IDLE;
      st_q.bit_count     <= 4'd0;
      st_q.shift_byte    <= 8'd0;
      st_q.is_read       <= 1'b0;
      st_q.saved_control <= 8'd0;
      st_q.saved_data    <= 8'd0;
      st_q.received_byte <= 8'd0;
      st_q.error_flag    <= 1'b0;
      st_q.scl           <= 1'b1;
      st_q.sda           <= 1'b1;
    end else if (in_acc) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = res_q;

  // A held result blocks the input side.
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |-> !in_ready_o)
    else $error("input accepted while result stalled");

  // Every accepted item yields a result on the next cycle.
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_o)
    else $error("accepted item produced no result");

  // Reported busy matches the sequencer phase that the item left behind.
  a_busy_matches_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (out_item_o.busy_res == (st_q.phase != PH_IDLE)))
    else $error("busy flag disagrees with sequencer phase");

endmodule

// ===== rtl/core/i2c_adm_seq.sv =====
// One-tick next-state and result logic of the I2C transaction sequencer.
// Purely combinational; uses i2c_adm_pkg.
`timescale 1ns / 1ps

module i2c_adm_seq (
  input  i2c_adm_pkg::seq_state_t st_i,
  input  i2c_adm_pkg::in_item_t   item_i,
  input  logic [6:0]              dev_addr_i,
  output i2c_adm_pkg::seq_state_t st_o,
  output i2c_adm_pkg::out_item_t  res_o
);
  import i2c_adm_pkg::*;

  logic [7:0] addr_w;
  logic       done;

  assign addr_w = {dev_addr_i, 1'b0};

  always_comb begin
    st_o = st_i;
    done = 1'b0;
    case (st_i.phase)
      PH_IDLE: begin
        if (item_i.command == CMD_READ || item_i.command == CMD_WRITE) begin
          st_o.is_read       = (item_i.command == CMD_READ);
          st_o.saved_control = item_i.control_byte;
          st_o.saved_data    = item_i.write_data;
          st_o.error_flag    = 1'b0;
          st_o.scl           = 1'b1;
          st_o.sda           = 1'b1;
          st_o.phase         = PH_START2;
        end
      end
      PH_START2, PH_START2R: begin
        st_o.scl        = 1'b1;
        st_o.sda        = 1'b0;
        st_o.bit_count  = 4'd0;
        st_o.phase      = (st_i.phase == PH_START2) ? PH_ADDRW : PH_ADDRR;
        st_o.shift_byte = (st_i.phase == PH_START2) ? addr_w : (addr_w | 8'h01);
      end
      PH_ADDRW, PH_CTRL, PH_DATA, PH_ADDRR: begin
        if (!st_i.bit_count[3]) begin
          st_o.scl        = 1'b1;
          st_o.sda        = st_i.shift_byte[7];
          st_o.shift_byte = {st_i.shift_byte[6:0], 1'b0};
          st_o.bit_count  = st_i.bit_count + 4'd1;
        end else begin
          st_o.scl = 1'b0;
          // byte done: move to its first ack tick
          case (st_i.phase)
            PH_ADDRW: st_o.phase = PH_ADDRW_A1;
            PH_CTRL:  st_o.phase = PH_CTRL_A1;
            PH_DATA:  st_o.phase = PH_DATA_A1;
            default:  st_o.phase = PH_ADDRR_A1;
          endcase
        end
      end
      PH_ADDRW_A1, PH_CTRL_A1, PH_DATA_A1, PH_ADDRR_A1: begin
        st_o.scl        = 1'b1;
        st_o.sda        = 1'b1;
        st_o.error_flag = item_i.sda_in;
        case (st_i.phase)
          PH_ADDRW_A1: st_o.phase = PH_ADDRW_A2;
          PH_CTRL_A1:  st_o.phase = PH_CTRL_A2;
          PH_DATA_A1:  st_o.phase = PH_DATA_A2;
          default:     st_o.phase = PH_ADDRR_A2;
        endcase
      end
      PH_ADDRW_A2, PH_CTRL_A2, PH_DATA_A2, PH_ADDRR_A2: begin
        st_o.scl = 1'b0;
        st_o.sda = 1'b1;
        if (st_i.error_flag) begin
          // missing ack: abort without STOP
          st_o.received_byte = 8'd0;
          st_o.phase         = PH_IDLE;
          done               = 1'b1;
        end else begin
          case (st_i.phase)
            PH_ADDRW_A2: begin
              st_o.phase      = PH_CTRL;
              st_o.shift_byte = st_i.saved_control;
              st_o.bit_count  = 4'd0;
            end
            PH_CTRL_A2: begin
              if (st_i.is_read) begin
                st_o.phase = PH_STOPM1;
              end else begin
                st_o.phase      = PH_DATA;
                st_o.shift_byte = st_i.saved_data;
                st_o.bit_count  = 4'd0;
              end
            end
            PH_DATA_A2: st_o.phase = PH_STOP1;
            default: begin
              st_o.phase      = PH_RECV;
              st_o.bit_count  = 4'd0;
              st_o.shift_byte = 8'd0;
            end
          endcase
        end
      end
      PH_STOPM1, PH_STOP1: begin
        st_o.scl   = 1'b1;
        st_o.sda   = 1'b0;
        st_o.phase = (st_i.phase == PH_STOPM1) ? PH_STOPM2 : PH_STOP2;
      end
      PH_STOPM2: begin
        st_o.scl   = 1'b1;
        st_o.sda   = 1'b1;
        st_o.phase = PH_START1R;
      end
      PH_START1R: begin
        st_o.scl   = 1'b1;
        st_o.sda   = 1'b1;
        st_o.phase = PH_START2R;
      end
      PH_RECV: begin
        st_o.scl        = 1'b1;
        st_o.sda        = 1'b1;
        st_o.shift_byte = {st_i.shift_byte[6:0], item_i.sda_in};
        st_o.bit_count  = st_i.bit_count + 4'd1;
        if (st_o.bit_count[3]) begin
          st_o.phase = PH_NACK1;
        end
      end
      PH_NACK1: begin
        st_o.scl   = 1'b1;
        st_o.sda   = 1'b1;
        st_o.phase = PH_NACK2;
      end
      PH_NACK2: begin
        st_o.scl   = 1'b0;
        st_o.sda   = 1'b0;
        st_o.phase = PH_STOP1;
      end
      PH_STOP2: begin
        st_o.scl = 1'b1;
        st_o.sda = 1'b1;
        if (st_i.is_read) begin
          st_o.received_byte = st_i.shift_byte;
        end
        st_o.phase = PH_IDLE;
        done       = 1'b1;
      end
      default: begin
        st_o.phase = PH_IDLE;
      end
    endcase
  end

  assign res_o.scl_out   = st_o.scl;
  assign res_o.sda_out   = st_o.sda;
  assign res_o.busy_res  = (st_o.phase != PH_IDLE);
  assign res_o.done_res  = done;
  assign res_o.read_data = st_o.received_byte;
  assign res_o.ack_error = st_o.error_flag;

endmodule

// ===== tb/i2c_adm_line_checker.sv =====
// Checker for the I2C converter transaction master: predicts every result item
// from the accepted input items and the device address writes, and compares.
// Depends on i2c_adm_pkg for the item structs, command and phase codes.
`timescale 1ns / 1ps

module i2c_adm_line_checker
  import i2c_adm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  in_item_t   in_item_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  out_item_t  out_item_i,
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_data_i,
  output int         mismatches_o,
  output int         pending_o
);

  // sequencer copy
  logic [6:0] dev_addr;
  phase_e     phase;
  logic [3:0] bit_count;
  logic [7:0] shift_byte;
  logic       is_read;
  logic [7:0] saved_control;
  logic [7:0] saved_data;
  logic [7:0] rx_byte;
  logic       ack_missed;
  logic       line_scl;
  logic       line_sda;

  out_item_t  expected_levels[$];
  out_item_t  want;
  int         mismatch_count;
  int         results_seen;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 30) begin
      $display("%0t chk: result %0d: %s", $time, results_seen, msg);
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] got,
                             input logic [7:0] exp);
    if (got !== exp) begin
      report_mismatch($sformatf("%s got %0h want %0h", name, got, exp));
    end
  endtask

  function automatic void load_byte(input phase_e next, input logic [7:0] b);
    phase      = next;
    shift_byte = b;
    bit_count  = 4'd0;
  endfunction

  // One bus tick: advance the sequencer copy and return the levels it shows.
  function automatic out_item_t next_bus_levels(input in_item_t it);
    out_item_t res;
    logic      done;
    done = 1'b0;
    case (phase)
      PH_IDLE: begin
        if (it.command == CMD_READ || it.command == CMD_WRITE) begin
          is_read       = (it.command == CMD_READ);
          saved_control = it.control_byte;
          saved_data    = it.write_data;
          ack_missed    = 1'b0;
          line_scl      = 1'b1;
          line_sda      = 1'b1;
          phase         = PH_START2;
        end
      end
      PH_START2: begin
        line_scl = 1'b1;
        line_sda = 1'b0;
        load_byte(PH_ADDRW, {dev_addr, 1'b0});
      end
      PH_START2R: begin
        line_scl = 1'b1;
        line_sda = 1'b0;
        load_byte(PH_ADDRR, {dev_addr, 1'b1});
      end
      PH_ADDRW, PH_CTRL, PH_DATA, PH_ADDRR: begin
        if (bit_count < 4'd8) begin
          line_sda   = shift_byte[7];
          line_scl   = 1'b1;
          shift_byte = {shift_byte[6:0], 1'b0};
          bit_count  = bit_count + 4'd1;
        end else begin
          line_scl = 1'b0;
          phase    = phase_e'(phase + 5'd1);
        end
      end
      PH_ADDRW_A1, PH_CTRL_A1, PH_DATA_A1, PH_ADDRR_A1: begin
        line_scl   = 1'b1;
        line_sda   = 1'b1;
        ack_missed = it.sda_in;
        phase      = phase_e'(phase + 5'd1);
      end
      PH_ADDRW_A2, PH_CTRL_A2, PH_DATA_A2, PH_ADDRR_A2: begin
        line_scl = 1'b0;
        line_sda = 1'b1;
        if (ack_missed) begin
          // abort: no STOP, lines left at SCL low / SDA released
          rx_byte = 8'd0;
          phase   = PH_IDLE;
          done    = 1'b1;
        end else begin
          case (phase)
            PH_ADDRW_A2: load_byte(PH_CTRL, saved_control);
            PH_CTRL_A2: begin
              if (is_read) phase = PH_STOPM1;
              else load_byte(PH_DATA, saved_data);
            end
            PH_DATA_A2: phase = PH_STOP1;
            default: begin
              phase      = PH_RECV;
              bit_count  = 4'd0;
              shift_byte = 8'd0;
            end
          endcase
        end
      end
      PH_STOPM1: begin
        line_scl = 1'b1;
        line_sda = 1'b0;
        phase    = PH_STOPM2;
      end
      PH_STOPM2: begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        phase    = PH_START1R;
      end
      PH_START1R: begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        phase    = PH_START2R;
      end
      PH_RECV: begin
        line_scl   = 1'b1;
        line_sda   = 1'b1;
        shift_byte = {shift_byte[6:0], it.sda_in};
        bit_count  = bit_count + 4'd1;
        if (bit_count >= 4'd8) phase = PH_NACK1;
      end
      PH_NACK1: begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        phase    = PH_NACK2;
      end
      PH_NACK2: begin
        line_scl = 1'b0;
        line_sda = 1'b0;
        phase    = PH_STOP1;
      end
      PH_STOP1: begin
        line_scl = 1'b1;
        line_sda = 1'b0;
        phase    = PH_STOP2;
      end
      PH_STOP2: begin
        line_scl = 1'b1;
        line_sda = 1'b1;
        if (is_read) rx_byte = shift_byte;
        phase = PH_IDLE;
        done  = 1'b1;
      end
      default: phase = PH_IDLE;
    endcase
    res.scl_out   = line_scl;
    res.sda_out   = line_sda;
    res.busy_res  = (phase != PH_IDLE);
    res.done_res  = done;
    res.read_data = rx_byte;
    res.ack_error = ack_missed;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr       = DevAddrReset;
      phase          = PH_IDLE;
      bit_count      = 4'd0;
      shift_byte     = 8'd0;
      is_read        = 1'b0;
      saved_control  = 8'd0;
      saved_data     = 8'd0;
      rx_byte        = 8'd0;
      ack_missed     = 1'b0;
      line_scl       = 1'b1;
      line_sda       = 1'b1;
      mismatch_count = 0;
      results_seen   = 0;
      expected_levels.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("result item with nothing pending");
        end else begin
          want = expected_levels.pop_front();
          check_field("scl_out", out_item_i.scl_out, want.scl_out);
          check_field("sda_out", out_item_i.sda_out, want.sda_out);
          check_field("busy_res", out_item_i.busy_res, want.busy_res);
          check_field("done_res", out_item_i.done_res, want.done_res);
          check_field("read_data", out_item_i.read_data, want.read_data);
          check_field("ack_error", out_item_i.ack_error, want.ack_error);
        end
        results_seen++;
      end
      if (in_valid_i && in_ready_i) begin
        expected_levels.push_back(next_bus_levels(in_item_i));
      end
      if (cfg_we_i) dev_addr = cfg_data_i;
      mismatches_o <= mismatch_count;
      pending_o    <= expected_levels.size();
    end
  end

endmodule

// ===== tb/tb_i2c_adc_dac_transaction_master_unit.sv =====
// Testbench top for the I2C converter transaction master: drives bus ticks,
// device address writes and receiver stalls, and gives the verdict.
// Depends on i2c_adm_pkg, i2c_adm_line_checker and the unit under test.
`timescale 1ns / 1ps

module tb_i2c_adc_dac_transaction_master_unit;
  import i2c_adm_pkg::*;

  // command value the block treats as a plain tick
  localparam logic [1:0] CmdUnused = 2'd3;
  localparam int PhaseItems  = 290;   // counted items per address setting
  localparam int FlushTicks  = 52;    // longer than the longest transaction
  localparam int HoldCycles  = 64;    // receiver hold-off length
  localparam int StallLimit  = 600;   // cycles with no progress at all

  // which acknowledge the device fails to give, if any
  typedef enum int {
    NoMiss,
    MissAddr,
    MissCtrl,
    MissLast
  } ack_miss_e;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  in_item_t   in_item;
  logic       out_valid;
  logic       out_ready;
  out_item_t  out_item;
  logic       cfg_we;
  logic [6:0] cfg_data;

  int mismatches;
  int pending;
  int holds_asked;
  int holds_done;
  int idle_cycles;
  bit quiet_stretch;    // both sides run without gaps while set

  i2c_adc_dac_transaction_master_unit DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_data_i  (cfg_data)
  );

  i2c_adm_line_checker line_chk (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_data_i   (cfg_data),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Offer one item and hold it until the handshake; afterwards maybe idle a
  // few cycles. Valid is only lowered on a step of its own, never in the
  // same step where the next item raises it again.
  task automatic send_item(input in_item_t it);
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    while (!quiet_stretch && $urandom_range(99) < 26) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  // Stop offering and wait until every predicted result item has come back.
  // The first edge lets the checker count the last accepted item.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Ticks that carry no transaction start: command tick or the unused code,
  // or with any_cmd set, fully random commands (broken sequences).
  task automatic send_filler(input int count, input bit any_cmd);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      it.command      = any_cmd ? 2'($urandom_range(3))
                                : ($urandom_range(1) ? CMD_TICK : CmdUnused);
      it.control_byte = 8'($urandom_range(255));
      it.write_data   = 8'($urandom_range(255));
      it.sda_in       = 1'($urandom_range(1));
      send_item(it);
    end
  endtask

  // One whole transaction from an idle block. Tick offsets from the command
  // tick: the acknowledge samples fall on 11 and 22, then 37 for a read
  // (address-read byte) or 33 for a write (data byte); a read shifts its
  // byte in on 39..46, MSB first. A missed acknowledge ends the transaction
  // on the tick after the sample. All other ticks carry random commands and
  // bytes, which a busy block must ignore.
  task automatic run_bus_txn(input cmd_e cmd, input logic [7:0] ctrl,
                             input logic [7:0] wdat, input logic [7:0] rx,
                             input ack_miss_e miss, output int sent);
    in_item_t it;
    int       ack_at [3];
    int       len;
    bit       rd;
    rd     = (cmd == CMD_READ);
    ack_at = '{11, 22, rd ? 37 : 33};
    len    = (miss == NoMiss) ? (rd ? 51 : 37) : ack_at[int'(miss) - 1] + 2;
    for (int i = 0; i < len; i++) begin
      it.command      = (i == 0) ? cmd  : 2'($urandom_range(3));
      it.control_byte = (i == 0) ? ctrl : 8'($urandom_range(255));
      it.write_data   = (i == 0) ? wdat : 8'($urandom_range(255));
      it.sda_in       = 1'($urandom_range(1));
      if (i == ack_at[0] || i == ack_at[1] || i == ack_at[2]) begin
        it.sda_in = (miss != NoMiss && i == ack_at[int'(miss) - 1]);
      end else if (rd && i >= 39 && i <= 46) begin
        it.sda_in = rx[46 - i];
      end
      send_item(it);
    end
    sent = len;
  endtask

  // Flush any half-done transaction, let the block settle, then write the
  // device address while nothing is in flight.
  task automatic write_address(input logic [6:0] addr);
    send_filler(FlushTicks, 1'b0);
    wait_drained();
    repeat (3) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= addr;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // Receiver: random back-pressure, none during the quiet stretch, and a long
  // hold-off whenever the stimulus asks for one.
  initial begin
    holds_done = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        out_ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
      end else begin
        out_ready <= quiet_stretch || ($urandom_range(99) >= 26);
      end
    end
  end

  // Watchdog: any handshake, config write or reset cycle counts as progress.
  initial begin
    idle_cycles = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we || !rst_n) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [6:0] addr_plan [4];
    ack_miss_e  miss;
    int         counted;
    int         n;
    int         pick;
    bit         paused;

    quiet_stretch = 1'b0;
    holds_asked   = 0;
    paused        = 1'b0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    cfg_we   <= 1'b0;
    cfg_data <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part at the reset address: byte extremes both ways, every
    // acknowledge missed once per direction, and plain / unused-code ticks
    // so the held line levels after a finish and after an abort show up.
    run_bus_txn(CMD_READ,  8'h00, 8'h00, 8'hFF, NoMiss, n);
    run_bus_txn(CMD_WRITE, 8'hFF, 8'h00, 8'h00, NoMiss, n);
    run_bus_txn(CMD_WRITE, 8'h00, 8'hFF, 8'h00, NoMiss, n);
    send_filler(3, 1'b0);
    run_bus_txn(CMD_READ,  8'hFF, 8'hFF, 8'h00, NoMiss, n);
    run_bus_txn(CMD_READ,  8'h5A, 8'h00, 8'hA5, MissAddr, n);
    send_filler(3, 1'b0);
    run_bus_txn(CMD_READ,  8'hA5, 8'h00, 8'h5A, MissCtrl, n);
    run_bus_txn(CMD_READ,  8'h3C, 8'h00, 8'hC3, MissLast, n);
    run_bus_txn(CMD_WRITE, 8'h81, 8'h7E, 8'h00, MissAddr, n);
    run_bus_txn(CMD_WRITE, 8'h7E, 8'h81, 8'h00, MissCtrl, n);
    run_bus_txn(CMD_WRITE, 8'hC3, 8'h3C, 8'h00, MissLast, n);
    send_filler(4, 1'b0);

    // Random part: four address settings, extremes first.
    addr_plan = '{7'd0, 7'd127, 7'($urandom_range(127)), 7'($urandom_range(127))};
    for (int ph = 0; ph < 4; ph++) begin
      write_address(addr_plan[ph]);
      quiet_stretch = (ph == 1);
      counted = 0;
      while (counted < PhaseItems) begin
        // one long receiver hold-off while items keep coming
        if (ph == 2 && holds_asked == 0 && counted > 100) holds_asked++;
        // one sender pause until every result item is back
        if (ph == 3 && !paused && counted > 200) begin
          wait_drained();
          paused = 1'b1;
        end
        pick = $urandom_range(99);
        if (pick < 70) begin
          miss = ($urandom_range(7) == 0) ? ack_miss_e'($urandom_range(1, 3)) : NoMiss;
          run_bus_txn($urandom_range(1) ? CMD_READ : CMD_WRITE,
                      8'($urandom_range(255)), 8'($urandom_range(255)),
                      8'($urandom_range(255)), miss, n);
          counted += n;
        end else if (pick < 85) begin
          n = $urandom_range(1, 8);
          send_filler(n, 1'b0);
          counted += n;
        end else begin
          // broken sequence, then a flush so the next transaction lines up
          n = $urandom_range(1, 30);
          send_filler(n, 1'b1);
          send_filler(FlushTicks, 1'b0);
          counted += n + FlushTicks;
        end
      end
    end
    quiet_stretch = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== i2c_adc_dac_transaction_master_unit.f =====
rtl/core/i2c_adm_pkg.sv
rtl/core/i2c_adm_seq.sv
rtl/core/i2c_adc_dac_transaction_master_unit.sv
tb/i2c_adm_line_checker.sv
tb/tb_i2c_adc_dac_transaction_master_unit.sv
